// ----- sv/pal_pkg.sv -----
package pal_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CMD_W      = 3;
    localparam int POS_W      = 7;
    localparam int CNT_W      = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_FIND   = 3'd2,
        CMD_MODIFY = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PUT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                  we;
        logic [ADDR_W-1:0]     waddr;
        logic [DATA_WIDTH-1:0] wdata;
        logic                  re;
        logic [ADDR_W-1:0]     raddr;
    } mem_req_t;

    typedef struct packed {
        logic                  status;
        logic [POS_W-1:0]      found;
        logic [DATA_WIDTH-1:0] rd;
        logic [CNT_W-1:0]      len;
    } result_t;

endpackage

// ----- sv/pal_ram.sv -----
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/pal_ctrl.sv -----
module pal_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pal_pkg::CMD_W-1:0]          in_cmd,
    input  logic [pal_pkg::POS_W-1:0]          in_pos,
    input  logic [pal_pkg::DATA_WIDTH-1:0]     in_val,
    output pal_pkg::mem_req_t                  mem_req,
    input  logic [pal_pkg::DATA_WIDTH-1:0]     mem_rdata,
    output logic                               res_valid,
    input  logic                               res_ready,
    output pal_pkg::result_t                   res
);

    localparam int AW = pal_pkg::ADDR_W;
    localparam int PW = pal_pkg::POS_W;
    localparam int CW = pal_pkg::CNT_W;
    localparam int DW = pal_pkg::DATA_WIDTH;

    pal_pkg::state_t state_reg, state_next;

    logic [CW-1:0]             cnt_reg, cnt_next;
    logic [pal_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [DW-1:0]             val_reg, val_next;
    logic [AW-1:0]             put_reg, put_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             last_reg, last_next;
    logic                      more_reg, more_next;
    logic                      pend_reg, pend_next;
    logic [PW-1:0]             dst_reg, dst_next;
    logic                      status_reg, status_next;
    logic [PW-1:0]             found_reg, found_next;
    logic [DW-1:0]             rd_reg, rd_next;

    // command decode, evaluated against the current length
    pal_pkg::state_t dec_go;
    logic            dec_status;
    logic [CW-1:0]   dec_cnt;
    logic [AW-1:0]   dec_idx;
    logic [AW-1:0]   dec_last;
    logic [AW-1:0]   dec_put;
    logic [CW:0]     cnt_plus;
    logic [PW-1:0]   pos_m1;
    logic [CW-1:0]   cnt_m1;
    logic            pos_in_list;
    logic            ins_ok;

    logic accept;
    logic shifting;
    logic hit;
    logic rd_cap;
    logic walk_end;

    assign accept      = in_valid && in_ready;
    assign cnt_plus    = {1'b0, cnt_reg} + (CW+1)'(1);
    assign pos_m1      = in_pos - PW'(1);
    assign cnt_m1      = cnt_reg - CW'(1);
    assign pos_in_list = (in_pos != '0) && (in_pos <= cnt_reg);
    assign ins_ok      = (cnt_reg < CW'(pal_pkg::CAPACITY)) && (in_pos != '0)
                         && ({1'b0, in_pos} <= cnt_plus);

    always_comb begin
        dec_go     = pal_pkg::ST_DONE;
        dec_status = 1'b1;
        dec_cnt    = cnt_reg;
        dec_idx    = AW'(pos_m1);
        dec_last   = AW'(pos_m1);
        dec_put    = AW'(pos_m1);
        unique case (in_cmd)
            pal_pkg::CMD_INSERT: begin
                if (ins_ok) begin
                    dec_status = 1'b0;
                    dec_cnt    = cnt_plus[CW-1:0];
                    if ({1'b0, in_pos} == cnt_plus) begin
                        dec_go = pal_pkg::ST_PUT;
                    end else begin
                        dec_go  = pal_pkg::ST_WALK;
                        dec_idx = AW'(cnt_m1);
                    end
                end
            end
            pal_pkg::CMD_DELETE: begin
                if (pos_in_list) begin
                    dec_status = 1'b0;
                    dec_cnt    = cnt_m1;
                    if (in_pos != cnt_reg) begin
                        dec_go   = pal_pkg::ST_WALK;
                        dec_idx  = AW'(in_pos);
                        dec_last = AW'(cnt_m1);
                    end
                end
            end
            pal_pkg::CMD_FIND: begin
                if (cnt_reg != '0) begin
                    dec_status = 1'b0;
                    dec_go     = pal_pkg::ST_WALK;
                    dec_idx    = '0;
                    dec_last   = AW'(cnt_m1);
                end
            end
            pal_pkg::CMD_MODIFY: begin
                if (pos_in_list) begin
                    dec_status = 1'b0;
                    dec_go     = pal_pkg::ST_PUT;
                end
            end
            pal_pkg::CMD_READ: begin
                if (pos_in_list) begin
                    dec_status = 1'b0;
                    dec_go     = pal_pkg::ST_WALK;
                end
            end
            pal_pkg::CMD_CLEAR: begin
                dec_status = 1'b0;
                dec_cnt    = '0;
            end
            default: begin
                dec_status = 1'b1;
            end
        endcase
    end

    // walk: one RAM read per cycle, data used (compared or written back) in the cycle after its read
    assign shifting = (cmd_reg == pal_pkg::CMD_INSERT) || (cmd_reg == pal_pkg::CMD_DELETE);
    assign hit      = pend_reg && (cmd_reg == pal_pkg::CMD_FIND) && (mem_rdata == val_reg);
    assign rd_cap   = pend_reg && (cmd_reg == pal_pkg::CMD_READ);
    assign walk_end = hit || rd_cap || (!more_reg && !pend_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pal_pkg::ST_IDLE: begin
                if (in_valid) begin
                    state_next = dec_go;
                end
            end
            pal_pkg::ST_WALK: begin
                if (walk_end) begin
                    state_next = (cmd_reg == pal_pkg::CMD_INSERT) ? pal_pkg::ST_PUT
                                                                  : pal_pkg::ST_DONE;
                end
            end
            pal_pkg::ST_PUT: begin
                state_next = pal_pkg::ST_DONE;
            end
            pal_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = pal_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pal_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready   = (state_reg == pal_pkg::ST_IDLE);
        res_valid  = (state_reg == pal_pkg::ST_DONE);
        res.status = status_reg;
        res.found  = found_reg;
        res.rd     = rd_reg;
        res.len    = cnt_reg;
        mem_req    = '0;
        unique case (state_reg)
            pal_pkg::ST_WALK: begin
                if (pend_reg && shifting) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = dst_reg[AW-1:0];
                    mem_req.wdata = mem_rdata;
                end
                if (!hit && !rd_cap && more_reg) begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = idx_reg;
                end
            end
            pal_pkg::ST_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = put_reg;
                mem_req.wdata = val_reg;
            end
            default: begin
                mem_req = '0;
            end
        endcase
    end

    always_comb begin
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        val_next    = val_reg;
        put_next    = put_reg;
        idx_next    = idx_reg;
        last_next   = last_reg;
        more_next   = more_reg;
        pend_next   = pend_reg;
        dst_next    = dst_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rd_next     = rd_reg;
        if (accept) begin
            cmd_next    = in_cmd;
            val_next    = in_val;
            put_next    = dec_put;
            idx_next    = dec_idx;
            last_next   = dec_last;
            more_next   = 1'b1;
            pend_next   = 1'b0;
            status_next = dec_status;
            found_next  = '0;
            rd_next     = '0;
            cnt_next    = dec_cnt;
        end else if (state_reg == pal_pkg::ST_WALK) begin
            if (hit) begin
                found_next = dst_reg;
                pend_next  = 1'b0;
                more_next  = 1'b0;
            end else if (rd_cap) begin
                rd_next   = mem_rdata;
                pend_next = 1'b0;
            end else if (more_reg) begin
                pend_next = 1'b1;
                dst_next  = (cmd_reg == pal_pkg::CMD_DELETE) ? PW'(idx_reg) - PW'(1)
                                                             : PW'(idx_reg) + PW'(1);
                idx_next  = (cmd_reg == pal_pkg::CMD_INSERT) ? idx_reg - AW'(1)
                                                             : idx_reg + AW'(1);
                more_next = (idx_reg != last_reg);
            end else begin
                pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pal_pkg::ST_IDLE;
            cnt_reg   <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        put_reg    <= put_next;
        idx_reg    <= idx_next;
        last_reg   <= last_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rd_reg     <= rd_next;
    end

endmodule

// ----- sv/positional_array_list_core.sv -----
// channel | direction | handshake          | payload
// s_      | in        | s_valid / s_ready  | s_command, s_position, s_value
// m_      | out       | m_valid / m_ready  | m_status, m_found_position, m_read_value,
//         |           |                    | m_list_length
//
// One command at a time. A walk is bound by the entry RAM's single read port: it
// reads one entry a cycle. Reset clears the length and control state; the entry
// RAM is not swept. A result waits in the output register; the next command is taken
// while it waits, and a finished command holds in its done state until the output
// register frees up.
module positional_array_list_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [pal_pkg::CMD_W-1:0]              s_command,
    input  logic [pal_pkg::POS_W-1:0]              s_position,
    input  logic signed [pal_pkg::DATA_WIDTH-1:0]  s_value,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic                                   m_status,
    output logic [pal_pkg::POS_W-1:0]              m_found_position,
    output logic signed [pal_pkg::DATA_WIDTH-1:0]  m_read_value,
    output logic [pal_pkg::CNT_W-1:0]              m_list_length
);

    pal_pkg::mem_req_t                mem_req;
    logic [pal_pkg::DATA_WIDTH-1:0]   mem_rdata;
    pal_pkg::result_t                 res;
    logic                             res_valid;
    logic                             res_ready;

    logic             out_valid_reg, out_valid_next;
    pal_pkg::result_t out_reg, out_next;

    pal_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_command),
        .in_pos    (s_position),
        .in_val    (s_value),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    pal_ram #(
        .WIDTH (pal_pkg::DATA_WIDTH),
        .DEPTH (pal_pkg::CAPACITY)
    ) u_entries (
        .aclk  (aclk),
        .we    (mem_req.we),
        .waddr (mem_req.waddr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.raddr),
        .rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready) begin
            out_next       = res;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_reg.status;
    assign m_found_position = out_reg.found;
    assign m_read_value     = out_reg.rd;
    assign m_list_length    = out_reg.len;

endmodule

// ----- sv/pal_checker.sv -----
module pal_checker (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic                                   m_status,
    input logic [pal_pkg::POS_W-1:0]              m_found_position,
    input logic signed [pal_pkg::DATA_WIDTH-1:0]  m_read_value,
    input logic [pal_pkg::CNT_W-1:0]              m_list_length
);

    // stalled result transaction keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_found_position)
                                && $stable(m_read_value) && $stable(m_list_length))
        else $error("result changed while stalled");

    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_list_length <= pal_pkg::CNT_W'(pal_pkg::CAPACITY))
        else $error("length above capacity");

    // a hit lies inside the list and comes with ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found_position != '0 |->
            !m_status && m_found_position <= m_list_length)
        else $error("bad found position");

    a_read_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_read_value != '0 |-> !m_status && m_found_position == '0
                                          && m_list_length != '0)
        else $error("read data on failed or non-read command");

endmodule

bind positional_array_list_core pal_checker u_pal_checker (.*);
